### design/pcc_pkg.sv
// Shared types and constants of the prime/composite counter.
package pcc_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COUNT_W = 32;

  typedef enum logic [1:0] {
    CLASS_ONE       = 2'd0,
    CLASS_PRIME     = 2'd1,
    CLASS_COMPOSITE = 2'd2,
    CLASS_ZERO      = 2'd3
  } class_e;

  typedef struct packed {
    logic [COUNT_W-1:0] primes;
    logic [COUNT_W-1:0] composites;
    logic [COUNT_W-1:0] ones;
  } counts_t;

  typedef struct packed {
    logic   en;
    class_e cls;
  } bump_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_status_t;

endpackage

### design/pcc_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface pcc_in_if;
  logic                        valid;
  logic                        ready;
  logic [pcc_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface pcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  number_class;
  logic [pcc_pkg::COUNT_W-1:0] primes_seen;
  logic [pcc_pkg::COUNT_W-1:0] composites_seen;
  logic [pcc_pkg::COUNT_W-1:0] ones_seen;

  modport source (output valid, output number_class, output primes_seen,
                  output composites_seen, output ones_seen, input ready);
  modport sink   (input valid, input number_class, input primes_seen,
                  input composites_seen, input ones_seen, output ready);
endinterface

### design/pcc_rem_unit.sv
// Iterative restoring remainder unit, one quotient bit per cycle.
module pcc_rem_unit #(
  parameter int unsigned VB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [VB-1:0]        dividend_i,
  input  logic [VB-1:0]        divisor_i,
  output pcc_pkg::rem_status_t status_o
);

  localparam int unsigned CNT_W = $clog2(VB + 1);

  logic [VB-1:0]    rem_q, rem_d;
  logic [VB-1:0]    sh_q, sh_d;
  logic [VB-1:0]    div_q, div_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [VB:0]      trial;
  logic [VB:0]      diff;

  assign trial = {rem_q, sh_q[VB-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      sh_d   = dividend_i;
      div_d  = divisor_i;
      cnt_d  = CNT_W'(VB);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // keep the difference when the trial does not go negative
      rem_d = diff[VB] ? trial[VB-1:0] : diff[VB-1:0];
      sh_d  = {sh_q[VB-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    div_q <= div_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign status_o.zero = (rem_q == '0);

endmodule

### design/pcc_counters.sv
// Saturating running counts of primes, composites and ones.
module pcc_counters (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcc_pkg::bump_t   bump_i,
  output pcc_pkg::counts_t counts_o
);

  pcc_pkg::counts_t cnt_q, cnt_d;

  function automatic logic [pcc_pkg::COUNT_W-1:0] sat_inc(
    input logic [pcc_pkg::COUNT_W-1:0] c
  );
    return (c == '1) ? c : c + pcc_pkg::COUNT_W'(1);
  endfunction

  always_comb begin
    cnt_d = cnt_q;
    if (bump_i.en) begin
      unique case (bump_i.cls)
        pcc_pkg::CLASS_ONE:       cnt_d.ones       = sat_inc(cnt_q.ones);
        pcc_pkg::CLASS_PRIME:     cnt_d.primes     = sat_inc(cnt_q.primes);
        pcc_pkg::CLASS_COMPOSITE: cnt_d.composites = sat_inc(cnt_q.composites);
        pcc_pkg::CLASS_ZERO:      cnt_d            = cnt_q;
        default:                  cnt_d            = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign counts_o = cnt_q;

endmodule

### design/prime_composite_counter.sv
// Top level: trial-division primality classifier with running counts.
// Each item is classified as zero, one, prime or composite by trying divisors d = 2, 3, ...
// while d*d does not exceed the value, the square being kept by running addition. Every
// trial is a remainder taken in the bit-serial remainder unit; a prime near 2^16
// tries about 255 divisors, while zero and one skip the trials altogether. The
// block takes one item at a time and is not ready while an item is being tested. The
// result waits in an output register, and the next item is accepted meanwhile. Counts
// saturate at all ones and the result carries them after the update.
module prime_composite_counter #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcc_in_if.sink    in_i,
  pcc_out_if.source out_o
);

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned SQ_W = VB + 2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WAIT,
    ST_FINISH
  } state_e;

  state_e              state_q;
  logic [VB-1:0]       n_q;
  logic [VB-1:0]       d_q;
  logic [SQ_W-1:0]     sq_q;
  pcc_pkg::class_e     cls_q;
  pcc_pkg::class_e     out_cls_q;
  logic                out_valid_q;

  logic [31:0]         value_ext;
  logic [VB-1:0]       n_in;
  logic                in_fire;
  logic                sq_fits;
  logic                out_load;
  logic                rem_start;
  pcc_pkg::rem_status_t rem_st;
  pcc_pkg::bump_t      bump;
  pcc_pkg::counts_t    counts;

  assign value_ext = 32'(in_i.value);
  assign n_in      = value_ext[VB-1:0];
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire   = in_i.valid && in_i.ready;
  assign sq_fits   = (sq_q <= SQ_W'(n_q));
  assign rem_start = (state_q == ST_CHECK) && sq_fits;
  assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || out_o.ready);

  assign bump.en  = out_load;
  assign bump.cls = cls_q;

  pcc_rem_unit #(.VB(VB)) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (n_q),
    .divisor_i  (d_q),
    .status_o   (rem_st)
  );

  pcc_counters u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bump_i   (bump),
    .counts_o (counts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      d_q         <= VB'(2);
      sq_q        <= SQ_W'(4);
      cls_q       <= pcc_pkg::CLASS_ZERO;
      out_cls_q   <= pcc_pkg::CLASS_ZERO;
      out_valid_q <= 1'b0;
      n_q         <= '0;
    end else begin
      if (out_valid_q && out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            n_q  <= n_in;
            d_q  <= VB'(2);
            sq_q <= SQ_W'(4);
            if (n_in == '0) begin
              cls_q   <= pcc_pkg::CLASS_ZERO;
              state_q <= ST_FINISH;
            end else if (n_in == VB'(1)) begin
              cls_q   <= pcc_pkg::CLASS_ONE;
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (sq_fits) begin
            state_q <= ST_WAIT;
          end else begin
            cls_q   <= pcc_pkg::CLASS_PRIME;
            state_q <= ST_FINISH;
          end
        end
        ST_WAIT: begin
          if (rem_st.done) begin
            if (rem_st.zero) begin
              cls_q   <= pcc_pkg::CLASS_COMPOSITE;
              state_q <= ST_FINISH;
            end else begin
              // advance to the next divisor: (d+1)^2 = d^2 + 2d + 1
              sq_q    <= sq_q + {1'b0, d_q, 1'b1};
              d_q     <= d_q + VB'(1);
              state_q <= ST_CHECK;
            end
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_cls_q   <= cls_q;
            d_q         <= VB'(2);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.number_class    = out_cls_q;
  assign out_o.primes_seen     = counts.primes;
  assign out_o.composites_seen = counts.composites;
  assign out_o.ones_seen       = counts.ones;

  a_rem_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_start |-> !rem_st.busy)
    else $error("remainder unit restarted while busy");

  a_counts_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(counts))
    else $error("counts changed while a result was pending");

  a_divisor_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> d_q >= VB'(2) && sq_q >= SQ_W'(4))
    else $error("trial divisor below two");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_st.done |-> state_q == ST_WAIT)
    else $error("remainder result outside wait state");

endmodule

### tb/tb.sv
// Self-checking testbench for the prime/composite counter, with a tally scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VALUE_BITS   = 16;
  localparam int unsigned RANDOM_ITEMS = 100;
  // Long enough to cover the test of a prime near the top of the range, with wide margin.
  localparam int unsigned STALL_LIMIT  = 40000;
  localparam int unsigned TAIL_CYCLES  = 5000;

  localparam logic [pcc_pkg::VALUE_W-1:0] EDGE_VALUES [22] = '{
    16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25, 16'd49, 16'd97,
    16'd121, 16'd63001, 16'd64507, 16'd65521, 16'd65519, 16'd65535, 16'd65534,
    16'd32768, 16'd32767, 16'h5555, 16'hAAAA, 16'd0
  };

  class tally_scoreboard;
    typedef struct packed {
      pcc_pkg::class_e  cls;
      pcc_pkg::counts_t counts;
    } tally_t;

    tally_t           awaited_tallies[$];
    pcc_pkg::counts_t running_counts;
    int unsigned      mismatches;

    function new();
      running_counts = '0;
      mismatches     = 0;
    endfunction

    function bit has_divisor(longint unsigned n);
      for (longint unsigned d = 2; d * d <= n; d++) begin
        if (n % d == 0) return 1'b1;
      end
      return 1'b0;
    endfunction

    function logic [pcc_pkg::COUNT_W-1:0] bump(logic [pcc_pkg::COUNT_W-1:0] c);
      return (c == '1) ? c : c + 1'b1;
    endfunction

    function int unsigned pending();
      return awaited_tallies.size();
    endfunction

    // Classify an accepted item and queue the tally it should produce.
    function void note_value(logic [pcc_pkg::VALUE_W-1:0] value);
      longint unsigned n;
      tally_t          t;
      n = longint'(value) & ((64'd1 << VALUE_BITS) - 64'd1);
      if (n == 0) begin
        t.cls = pcc_pkg::CLASS_ZERO;
      end else if (n == 1) begin
        t.cls = pcc_pkg::CLASS_ONE;
        running_counts.ones = bump(running_counts.ones);
      end else if (has_divisor(n)) begin
        t.cls = pcc_pkg::CLASS_COMPOSITE;
        running_counts.composites = bump(running_counts.composites);
      end else begin
        t.cls = pcc_pkg::CLASS_PRIME;
        running_counts.primes = bump(running_counts.primes);
      end
      t.counts = running_counts;
      awaited_tallies.push_back(t);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [1:0] cls, logic [pcc_pkg::COUNT_W-1:0] primes,
                      logic [pcc_pkg::COUNT_W-1:0] composites,
                      logic [pcc_pkg::COUNT_W-1:0] ones);
      tally_t t;
      if (awaited_tallies.size() == 0) begin
        report_mismatch($sformatf("unexpected result class %0d counts %0d/%0d/%0d",
                                  cls, primes, composites, ones));
        return;
      end
      t = awaited_tallies.pop_front();
      if (cls !== t.cls || primes !== t.counts.primes ||
          composites !== t.counts.composites || ones !== t.counts.ones) begin
        report_mismatch($sformatf("class %0d/%0d primes %0d/%0d composites %0d/%0d ones %0d/%0d",
                                  cls, t.cls, primes, t.counts.primes, composites,
                                  t.counts.composites, ones, t.counts.ones));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   quiet = 1'b0;

  tally_scoreboard sb = new();
  int unsigned     stall_cycles = 0;

  pcc_in_if  in_if ();
  pcc_out_if out_if ();

  prime_composite_counter #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_value(input logic [pcc_pkg::VALUE_W-1:0] v);
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Now and then, unless quiet, drop valid for a while, with junk on the payload.
  task automatic sender_gap();
    if (!quiet && $urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 6)) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        in_if.value <= pcc_pkg::VALUE_W'($urandom());
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result sink: random back-pressure, none while quiet.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  // Check results before noting a new item, so a result with nothing outstanding is caught.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      sb.check_result(out_if.number_class, out_if.primes_seen, out_if.composites_seen,
                      out_if.ones_seen);
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      sb.note_value(in_if.value);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned                   k;
    logic [pcc_pkg::VALUE_W-1:0]   v;
    in_if.valid = 1'b0;
    in_if.value = '0;
    rst_n       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (EDGE_VALUES[i]) begin
      sender_gap();
      send_value(EDGE_VALUES[i]);
    end

    // Hold off until every outstanding tally is back.
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= 30 && i < 70);
      sender_gap();
      k = $urandom_range(2, 255);
      case ($urandom_range(9))
        5:       v = pcc_pkg::VALUE_W'($urandom_range(0, 16));
        6, 7:    v = pcc_pkg::VALUE_W'(k * k);
        8:       v = pcc_pkg::VALUE_W'($urandom_range(65000, 65535));
        9:       v = pcc_pkg::VALUE_W'(k * $urandom_range(2, 255));
        default: v = pcc_pkg::VALUE_W'($urandom());
      endcase
      send_value(v);
    end
    quiet = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
design/pcc_pkg.sv
design/pcc_if.sv
design/pcc_rem_unit.sv
design/pcc_counters.sv
design/prime_composite_counter.sv
tb/tb.sv
